### src/c3pn_pkg.sv
// c3pn_pkg: shared types, constants and helpers for the 3x3 convolution block
// no dependencies; imported by every module of the block

package c3pn_pkg;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 20;
    localparam int COEF_W = 7;
    localparam int NTAPS  = 9;
    localparam int DIM_W  = 9;
    localparam int CFG_W  = 63;
    localparam int IDX_W  = 16;
    localparam int DIVD_W = 28;
    localparam int QUO_W  = 8;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [CFG_W-1:0] KERNEL_RESET = 63'd268435456;
    localparam logic [DIM_W-1:0] DIM_RESET    = 9'd256;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KERNEL = 2'd2;

    // request actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic               action;
        logic [PIX_W-1:0]   pixel_value;
        logic [IDX_W-1:0]   read_index;
    } request_t;

    typedef struct packed {
        logic [PIX_W-1:0]   out_pixel;
        logic               out_ready;
    } result_t;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } sum_wr_t;

    typedef struct packed {
        logic valid;
        logic in_range;
    } norm_req_t;

    function automatic logic signed [COEF_W-1:0] coeff_at(
        input logic [CFG_W-1:0] kernel,
        input logic [3:0]       k
    );
        return kernel[COEF_W*k +: COEF_W];
    endfunction

    // zero reads as one, above the maximum saturates
    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input int               maxv
    );
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > maxv)
            r = DIM_W'(maxv);
        return r;
    endfunction

endpackage

### src/c3pn_conv.sv
// c3pn_conv: pixel memory and the 3x3 convolution pass, one tap per cycle
// depends on c3pn_pkg

module c3pn_conv
    import c3pn_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load_we,
    input  logic [AW-1:0]           load_addr,
    input  logic [PIX_W-1:0]        load_data,
    input  logic                    go,
    input  logic [DIM_W-1:0]        width,
    input  logic [DIM_W-1:0]        height,
    input  logic [CFG_W-1:0]        kernel,
    output sum_wr_t                 sum_wr,
    output logic [AW-1:0]           sum_addr,
    output logic                    pass_done,
    output logic signed [SUM_W-1:0] peak
);

    localparam logic [3:0] LAST_TAP = 4'(NTAPS - 1);

    logic [PIX_W-1:0] pix_mem [DEPTH];
    logic [PIX_W-1:0] pix_q_reg;

    logic             run_reg;
    logic [DIM_W-1:0] x_reg, y_reg;
    logic [1:0]       kx_reg, ky_reg;
    logic [3:0]       tap_reg;
    logic [CNT_W-1:0] pix_addr_reg;

    logic             t_valid_reg, t_last_reg, t_final_reg;
    logic [3:0]       t_tap_reg;
    logic [AW-1:0]    t_addr_reg;

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] peak_reg;
    logic                    sw_valid_reg, done_reg;
    logic signed [SUM_W-1:0] sw_sum_reg;
    logic [AW-1:0]           sw_addr_reg;

    logic             x_last, y_last, last_tap, tap_ok;
    logic [CNT_W-1:0] w_ext, row_off, rd_full;
    logic [AW-1:0]    rd_addr;
    logic signed [PIX_W+COEF_W:0] prod;
    logic signed [SUM_W-1:0]      full;

    assign x_last   = (x_reg == width - DIM_W'(1));
    assign y_last   = (y_reg == height - DIM_W'(1));
    assign last_tap = (tap_reg == LAST_TAP);
    assign tap_ok   = !((kx_reg == 2'd0 && x_reg == '0) || (kx_reg == 2'd2 && x_last) ||
                        (ky_reg == 2'd0 && y_reg == '0) || (ky_reg == 2'd2 && y_last));
    assign w_ext    = CNT_W'(width);

    always_comb
    begin
        case (ky_reg)
            2'd0:    row_off = '0 - w_ext;
            2'd2:    row_off = w_ext;
            default: row_off = '0;
        endcase
    end

    assign rd_full = pix_addr_reg + row_off + CNT_W'(kx_reg) - CNT_W'(1);
    assign rd_addr = rd_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (load_we)
            pix_mem[load_addr] <= load_data;
        pix_q_reg <= pix_mem[rd_addr];
    end

    // tap sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            kx_reg       <= '0;
            ky_reg       <= '0;
            tap_reg      <= '0;
            pix_addr_reg <= '0;
        end
        else if (go)
        begin
            run_reg      <= 1'b1;
            x_reg        <= '0;
            y_reg        <= '0;
            kx_reg       <= '0;
            ky_reg       <= '0;
            tap_reg      <= '0;
            pix_addr_reg <= '0;
        end
        else if (run_reg)
        begin
            if (last_tap)
            begin
                kx_reg       <= '0;
                ky_reg       <= '0;
                tap_reg      <= '0;
                pix_addr_reg <= pix_addr_reg + CNT_W'(1);
                if (x_last)
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + DIM_W'(1);
                    if (y_last)
                        run_reg <= 1'b0;
                end
                else
                begin
                    x_reg <= x_reg + DIM_W'(1);
                end
            end
            else
            begin
                tap_reg <= tap_reg + 4'd1;
                if (kx_reg == 2'd2)
                begin
                    kx_reg <= '0;
                    ky_reg <= ky_reg + 2'd1;
                end
                else
                begin
                    kx_reg <= kx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            t_last_reg  <= 1'b0;
            t_final_reg <= 1'b0;
        end
        else
        begin
            t_valid_reg <= run_reg && tap_ok;
            t_last_reg  <= run_reg && last_tap;
            t_final_reg <= run_reg && last_tap && x_last && y_last;
        end
    end

    always_ff @(posedge clk)
    begin
        t_tap_reg  <= tap_reg;
        t_addr_reg <= pix_addr_reg[AW-1:0];
    end

    // multiply and accumulate
    assign prod = t_valid_reg ?
                  $signed({1'b0, pix_q_reg}) * coeff_at(kernel, t_tap_reg) :
                  $signed((PIX_W+COEF_W+1)'(0));
    assign full = acc_reg + SUM_W'(prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            peak_reg     <= -SUM_W'(1);
            sw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else if (go)
        begin
            acc_reg      <= '0;
            peak_reg     <= -SUM_W'(1);
            sw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            acc_reg      <= t_last_reg ? '0 : full;
            sw_valid_reg <= t_last_reg;
            done_reg     <= t_final_reg;
            if (t_last_reg && full > peak_reg)
                peak_reg <= full;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_sum_reg  <= full;
        sw_addr_reg <= t_addr_reg;
    end

    assign sum_wr.valid = sw_valid_reg;
    assign sum_wr.sum   = sw_sum_reg;
    assign sum_addr     = sw_addr_reg;
    assign pass_done    = done_reg;
    assign peak         = peak_reg;

endmodule

### src/c3pn_norm.sv
// c3pn_norm: sum memory and peak normalisation with an 8-step divider
// depends on c3pn_pkg

module c3pn_norm
    import c3pn_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sum_wr_t                 sum_wr,
    input  logic [AW-1:0]           sum_addr,
    input  norm_req_t               req,
    input  logic [AW-1:0]           rd_addr,
    input  logic signed [SUM_W-1:0] peak,
    output logic                    done,
    output logic [PIX_W-1:0]        pixel
);

    typedef enum logic [2:0] {
        N_IDLE = 3'b001,
        N_EVAL = 3'b010,
        N_DIV  = 3'b100
    } norm_state_t;

    logic signed [SUM_W-1:0] sum_mem [DEPTH];
    logic signed [SUM_W-1:0] rd_q_reg;

    norm_state_t       state_reg;
    logic              in_range_reg;
    logic [DIVD_W-1:0] rem_reg, dsr_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [2:0]        step_reg;
    logic              done_reg;
    logic [PIX_W-1:0]  pixel_reg;

    logic [DIVD_W-1:0] s_u, dvd;
    logic              ge;

    always_ff @(posedge clk)
    begin
        if (sum_wr.valid)
            sum_mem[sum_addr] <= sum_wr.sum;
        if (req.valid)
            rd_q_reg <= sum_mem[rd_addr];
    end

    assign s_u = DIVD_W'($unsigned(rd_q_reg));
    assign dvd = (s_u << 8) - s_u;
    assign ge  = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (req.valid)
                        state_reg <= N_EVAL;
                end
                N_EVAL:
                begin
                    if (!in_range_reg || (peak >= 0 && peak <= 255) || peak < 0 ||
                        rd_q_reg <= 0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        state_reg <= N_DIV;
                    end
                end
                N_DIV:
                begin
                    if (step_reg == 3'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
            in_range_reg <= req.in_range;
        case (state_reg)
            N_EVAL:
            begin
                if (!in_range_reg)
                    pixel_reg <= '0;
                else if (peak >= 0 && peak <= 255)
                    pixel_reg <= rd_q_reg[PIX_W-1:0];
                else if (peak < 0)
                    pixel_reg <= (rd_q_reg < 0) ? 8'hFF : '0;
                else
                    pixel_reg <= '0;
                rem_reg  <= dvd;
                dsr_reg  <= DIVD_W'($unsigned(peak)) << (QUO_W - 1);
                step_reg <= 3'(QUO_W - 1);
                q_reg    <= '0;
            end
            N_DIV:
            begin
                if (ge)
                    rem_reg <= rem_reg - dsr_reg;
                dsr_reg   <= dsr_reg >> 1;
                q_reg     <= {q_reg[QUO_W-2:0], ge};
                step_reg  <= step_reg - 3'd1;
                pixel_reg <= {q_reg[QUO_W-2:0], ge};
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign pixel = pixel_reg;

endmodule

### src/conv3x3_peak_normalize.sv
// conv3x3_peak_normalize: top level, configuration, load position and control
// depends on c3pn_pkg, c3pn_conv, c3pn_norm
//
//  channel   signals                          handshake
//  request   start, busy, request             taken when start && !busy
//  result    done, result                     done strobe, one cycle, no back-pressure
//  config    cfg_we, cfg_index, cfg_data      taken when cfg_we, no wait
//
// the last pixel of an image starts the pass, which holds busy until every pixel
// is convolved, its taps read through the single read port of the pixel memory
// a read strobes done once its sum is fetched and checked, or once the divider ends
// when the sum has to be scaled by the peak, one quotient bit per cycle in the normaliser
// after reset: width and height 256, identity kernel, no image complete, peak -1
// result strobes cannot be held off; busy alone paces incoming requests

module conv3x3_peak_normalize
    import c3pn_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  request_t         request,
    output logic             busy,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PASS = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t                  state_reg;
    logic [DIM_W-1:0]        width_reg, height_reg;
    logic [CFG_W-1:0]        kernel_reg;
    logic [CNT_W-1:0]        area_reg, load_pos_reg, count_reg;
    logic signed [SUM_W-1:0] peak_reg;
    logic                    complete_reg;

    logic [DIM_W-1:0]   cfg_w, cfg_h;
    logic [2*DIM_W-1:0] area_w, area_h;
    logic               accept, load_we, rd_go, go, hit;
    logic [CNT_W-1:0]   pos_inc;

    sum_wr_t                 sum_wr;
    logic [AW-1:0]           sum_addr;
    logic                    pass_done;
    logic signed [SUM_W-1:0] conv_peak;
    norm_req_t               nreq;
    logic                    norm_done;
    logic [PIX_W-1:0]        norm_pixel;

    // sizes are clamped on write; the area follows the new size at once
    assign cfg_w  = clamp_dim(cfg_data[DIM_W-1:0], MAX_WIDTH);
    assign cfg_h  = clamp_dim(cfg_data[DIM_W-1:0], MAX_HEIGHT);
    assign area_w = cfg_w * height_reg;
    assign area_h = width_reg * cfg_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_dim(DIM_RESET, MAX_WIDTH);
            height_reg <= clamp_dim(DIM_RESET, MAX_HEIGHT);
            kernel_reg <= KERNEL_RESET;
            area_reg   <= CNT_W'(clamp_dim(DIM_RESET, MAX_WIDTH)) *
                          CNT_W'(clamp_dim(DIM_RESET, MAX_HEIGHT));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:
                begin
                    width_reg <= cfg_w;
                    area_reg  <= CNT_W'(area_w);
                end
                CFG_HEIGHT:
                begin
                    height_reg <= cfg_h;
                    area_reg   <= CNT_W'(area_h);
                end
                CFG_KERNEL: kernel_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request decode
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign load_we = accept && (request.action == ACT_LOAD);
    assign rd_go   = accept && (request.action == ACT_READ);
    assign pos_inc = load_pos_reg + CNT_W'(1);
    assign hit     = (pos_inc >= area_reg);
    assign go      = load_we && hit;

    assign nreq.valid    = rd_go;
    assign nreq.in_range = complete_reg &&
                           (CMP_W'(request.read_index) < CMP_W'(count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_pos_reg <= '0;
            count_reg    <= '0;
            peak_reg     <= -SUM_W'(1);
            complete_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_we)
                    begin
                        // last pixel of the image kicks off the pass
                        load_pos_reg <= hit ? '0 : pos_inc;
                        if (hit)
                            state_reg <= ST_PASS;
                    end
                    else if (rd_go)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_PASS:
                begin
                    if (pass_done)
                    begin
                        state_reg    <= ST_IDLE;
                        complete_reg <= 1'b1;
                        peak_reg     <= conv_peak;
                        count_reg    <= area_reg;
                    end
                end
                ST_READ:
                begin
                    if (norm_done)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    c3pn_conv #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_we   (load_we),
        .load_addr (load_pos_reg[AW-1:0]),
        .load_data (request.pixel_value),
        .go        (go),
        .width     (width_reg),
        .height    (height_reg),
        .kernel    (kernel_reg),
        .sum_wr    (sum_wr),
        .sum_addr  (sum_addr),
        .pass_done (pass_done),
        .peak      (conv_peak)
    );

    c3pn_norm #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .sum_wr   (sum_wr),
        .sum_addr (sum_addr),
        .req      (nreq),
        .rd_addr  (AW'(request.read_index)),
        .peak     (peak_reg),
        .done     (norm_done),
        .pixel    (norm_pixel)
    );

    assign done             = norm_done;
    assign result.out_pixel = norm_pixel;
    assign result.out_ready = complete_reg;

    // a result strobe only closes a read request
    a_done_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_READ)
        else $error("result strobe outside a read request");

    // pass completion only while the pass is running
    a_pass_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        pass_done |-> state_reg == ST_PASS)
        else $error("pass finished outside pass state");

    // peak starts at minus one and never falls below it
    a_peak_floor: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= $signed(-SUM_W'(1)))
        else $error("peak below minus one");

    // a taken read holds the block busy
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_go |=> busy)
        else $error("read request taken without going busy");

    // no result may escape during the pass
    a_no_done_pass: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PASS |-> !done)
        else $error("result strobe during pass");

endmodule
